// File: hdl/lru_tag_cache_macros.svh
// assertion macros used by the lru tag cache checker
`ifndef LRU_TAG_CACHE_MACROS_SVH
`define LRU_TAG_CACHE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LTC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru tag cache check failed");

// next-cycle implication, sampled on clk, off during reset
`define LTC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru tag cache check failed");

`endif

// File: hdl/ltc_pkg.sv
// shared types and constants of the lru tag cache
`default_nettype none

package ltc_pkg;

	localparam int DEF_NUM_ENTRIES = 512;
	localparam int DEF_KEY_BITS    = 64;

	localparam int KEY_W     = 64;
	localparam int SLOT_W    = 9;
	localparam int ENT_OUT_W = 10;
	localparam int STAMP_W   = 32;
	localparam int STAT_W    = 32;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} ltc_state_t;

	// outcome of one finished request
	typedef struct packed {
		logic hit;
		logic miss;
		logic fill;
		logic evict;
	} ltc_flags_t;

endpackage

`default_nettype wire

// File: hdl/lru_tag_cache.sv
// top level of the fully associative lru tag cache
`default_nettype none

// Fully associative tag store with timestamp LRU replacement. Keys and their
// last-use stamps share one memory row per entry; entries fill in index order,
// so the valid set is always entries 0..entry_count-1 and is tracked by a
// fill count alone. A request is accepted when start is high and busy is low.
// A lookup scans the filled entries through the memory's single read port,
// one entry per cycle, and stops on the first match; an insert with a free
// entry writes it directly; an insert into a full store scans all entries
// for the smallest stamp. The scan length is set by the one read per cycle
// of the entry memory. Results appear for exactly one cycle with done high;
// the receiver cannot stall them. busy drops in the cycle that done is high,
// so a new request may be accepted at the same edge that ends the transfer.
// The counters always hold the values after the latest request and may be
// read at any time.

module lru_tag_cache import ltc_pkg::*; #(
	parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
	parameter int KEY_BITS    = DEF_KEY_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 action,
	input  wire logic [KEY_W-1:0]     key,
	input  wire logic                 count_miss,
	output logic                      done,
	output logic                      hit,
	output logic      [SLOT_W-1:0]    slot,
	output logic                      evicted,
	output logic      [STAT_W-1:0]    hit_count,
	output logic      [STAT_W-1:0]    miss_count,
	output logic      [STAT_W-1:0]    eviction_count,
	output logic      [ENT_OUT_W-1:0] entry_count
);

	localparam int IDX_W = $clog2(NUM_ENTRIES);
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
	localparam int ROW_W = KEY_BITS + STAMP_W;

	// sequencer <-> memory
	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [ROW_W-1:0] wr_data, rd_data;

	// finished request from the sequencer
	logic             fin;
	ltc_flags_t       flags;
	logic [IDX_W-1:0] fin_slot;

	// statistics and use clock
	logic [STAMP_W-1:0] tick_q;
	logic [STAT_W-1:0]  hits_q, misses_q, evictions_q;
	logic [CNT_W-1:0]   entries_q;

	// result registers
	logic              done_q, hit_q, evicted_q;
	logic [SLOT_W-1:0] slot_q;

	ltc_ctrl #(
		.NUM_ENTRIES(NUM_ENTRIES),
		.KEY_BITS   (KEY_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.key       (key),
		.count_miss(count_miss),
		.entries   (entries_q),
		.tick      (tick_q),
		.busy      (busy),
		.fin       (fin),
		.flags     (flags),
		.slot      (fin_slot),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	ltc_mem #(
		.DEPTH(NUM_ENTRIES),
		.WIDTH(ROW_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// counters move at the same edge the sequencer writes the stamp tick + 1,
	// so the next request already sees the advanced tick and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evictions_q <= '0;
			entries_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= fin;
			if (fin) begin
				// a hit or any insert restamps an entry
				if (flags.hit || flags.fill || flags.evict) begin
					tick_q <= tick_q + STAMP_W'(1);
				end
				if (flags.hit) begin
					hits_q <= hits_q + STAT_W'(1);
				end
				if (flags.miss) begin
					misses_q <= misses_q + STAT_W'(1);
				end
				if (flags.evict) begin
					evictions_q <= evictions_q + STAT_W'(1);
				end
				if (flags.fill) begin
					entries_q <= entries_q + CNT_W'(1);
				end
			end
		end
	end

	// result payload, valid while done is high
	always_ff @(posedge clk) begin
		if (fin) begin
			hit_q     <= flags.hit;
			evicted_q <= flags.evict;
			// a lookup miss leaves the sequencer's slot at zero
			slot_q    <= SLOT_W'(fin_slot);
		end
	end

	assign done           = done_q;
	assign hit            = hit_q;
	assign slot           = slot_q;
	assign evicted        = evicted_q;
	assign hit_count      = hits_q;
	assign miss_count     = misses_q;
	assign eviction_count = evictions_q;
	assign entry_count    = ENT_OUT_W'(entries_q);

endmodule

`default_nettype wire

// File: hdl/ltc_mem.sv
// single-port-write, registered-read entry memory
`default_nettype none

module ltc_mem #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 96,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/ltc_ctrl.sv
// request sequencer: scans the entry memory and writes back the chosen row
`default_nettype none

module ltc_ctrl import ltc_pkg::*; #(
	parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
	parameter int KEY_BITS    = DEF_KEY_BITS,
	localparam int IDX_W = $clog2(NUM_ENTRIES),
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1),
	localparam int ROW_W = KEY_BITS + STAMP_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               action,
	input  wire logic [KEY_W-1:0]   key,
	input  wire logic               count_miss,
	input  wire logic [CNT_W-1:0]   entries,
	input  wire logic [STAMP_W-1:0] tick,
	output logic                    busy,
	output logic                    fin,
	output ltc_flags_t              flags,
	output logic      [IDX_W-1:0]   slot,
	output logic                    wr_en,
	output logic      [IDX_W-1:0]   wr_addr,
	output logic      [ROW_W-1:0]   wr_data,
	output logic                    rd_en,
	output logic      [IDX_W-1:0]   rd_addr,
	input  wire logic [ROW_W-1:0]   rd_data
);

	ltc_state_t state_q, state_d;

	logic                act_q, cm_q, fill_q, hit_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0]    addr_q, last_q, slot_q, addr_s1;
	logic                iss_q, vld_s1;
	logic [STAMP_W-1:0]  min_q;

	logic                has_free, empty;
	logic [KEY_BITS-1:0] rd_key;
	logic [STAMP_W-1:0]  rd_stamp;
	logic                match, at_last;

	assign has_free = entries < CNT_W'(NUM_ENTRIES);
	assign empty    = entries == '0;
	assign rd_key   = rd_data[ROW_W-1:STAMP_W];
	assign rd_stamp = rd_data[STAMP_W-1:0];
	assign match    = rd_key == key_q;
	assign at_last  = addr_s1 == last_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_LOOKUP) begin
						state_d = empty ? ST_FIN : ST_SCAN;
					end else begin
						state_d = has_free ? ST_FIN : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (vld_s1) begin
					if (act_q == ACT_LOOKUP) begin
						if (match || at_last) begin
							state_d = ST_FIN;
						end
					end else if (at_last) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy        = state_q != ST_IDLE;
		rd_en       = (state_q == ST_SCAN) && iss_q;
		rd_addr     = addr_q;
		fin         = state_q == ST_FIN;
		wr_en       = fin && (hit_q || (act_q == ACT_INSERT));
		wr_addr     = slot_q;
		wr_data     = {key_q, tick + STAMP_W'(1)};
		slot        = slot_q;
		flags.hit   = hit_q;
		flags.miss  = (act_q == ACT_LOOKUP) && !hit_q && cm_q;
		flags.fill  = (act_q == ACT_INSERT) && fill_q;
		flags.evict = (act_q == ACT_INSERT) && !fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q   <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_SCAN) && iss_q;
			if (state_q == ST_IDLE) begin
				iss_q <= 1'b1;
			end else if ((state_q == ST_SCAN) && iss_q && (addr_q == last_q)) begin
				iss_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if ((state_q == ST_IDLE) && start) begin
			act_q  <= action;
			cm_q   <= count_miss;
			key_q  <= key[KEY_BITS-1:0];
			addr_q <= '0;
			min_q  <= '1;
			hit_q  <= 1'b0;
			fill_q <= has_free;
			slot_q <= ((action == ACT_INSERT) && has_free) ? IDX_W'(entries) : '0;
			last_q <= (action == ACT_LOOKUP) ? IDX_W'(entries - CNT_W'(1))
			                                 : IDX_W'(NUM_ENTRIES - 1);
		end else if (state_q == ST_SCAN) begin
			if (iss_q) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (vld_s1) begin
				if (act_q == ACT_LOOKUP) begin
					if (match) begin
						hit_q  <= 1'b1;
						slot_q <= addr_s1;
					end
				end else if (rd_stamp < min_q) begin
					// strict compare keeps the lowest index on ties
					min_q  <= rd_stamp;
					slot_q <= addr_s1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/ltc_chk.sv
// port-level checker for the lru tag cache, bound to the top level
`default_nettype none

`include "lru_tag_cache_macros.svh"

module ltc_chk import ltc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic                 done,
	input wire logic                 hit,
	input wire logic                 evicted,
	input wire logic [STAT_W-1:0]    hit_count,
	input wire logic [STAT_W-1:0]    eviction_count
);

	// a result frees the block for the next request
	`LTC_ASSERT_IMP(a_done_idle, done, !busy)

	// an accepted request always occupies the block
	`LTC_ASSERT_NXT(a_accept_busy, start && !busy, busy)

	// a lookup hit never evicts
	`LTC_ASSERT_IMP(a_hit_no_evict, done && hit, !evicted)

	// counters already include the reported outcome
	`LTC_ASSERT_IMP(a_hit_counted, done && hit, hit_count == $past(hit_count) + 32'd1)

	`LTC_ASSERT_IMP(a_evict_counted, done && evicted,
		eviction_count == $past(eviction_count) + 32'd1)

endmodule

bind lru_tag_cache ltc_chk u_ltc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.evicted       (evicted),
	.hit_count     (hit_count),
	.eviction_count(eviction_count)
);

`default_nettype wire

// File: test/tb_lru_tag_cache.sv
// self-checking testbench for the lru tag cache: directed and random lookups and inserts
module tb_lru_tag_cache;
	timeunit 1ns;
	timeprecision 1ps;

	import ltc_pkg::*;

	// size of the store under test, taken from the package defaults
	localparam int ENTRY_N = DEF_NUM_ENTRIES;
	// total requests to send before the run winds down
	localparam int ITEM_TARGET = 1170;
	// generous ceiling: every request a full eviction scan plus sender gaps, taken 3x over
	localparam int CYCLE_LIMIT = 2_000_000;
	// requests per idling phase; the sender drains before each new phase
	localparam int PHASE_LEN = 90;
	// cap on printed mismatch lines
	localparam int MAX_REPORTS = 40;

	// one expected result, field by field at the port widths
	typedef struct packed {
		logic                 hit;
		logic [SLOT_W-1:0]    slot;
		logic                 evicted;
		logic [STAT_W-1:0]    hit_count;
		logic [STAT_W-1:0]    miss_count;
		logic [STAT_W-1:0]    eviction_count;
		logic [ENT_OUT_W-1:0] entry_count;
	} cache_outcome_t;

	logic                 clk;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 action     = ACT_LOOKUP;
	logic [KEY_W-1:0]     key        = '0;
	logic                 count_miss = 1'b0;
	logic                 busy;
	logic                 done;
	logic                 hit;
	logic [SLOT_W-1:0]    slot;
	logic                 evicted;
	logic [STAT_W-1:0]    hit_count;
	logic [STAT_W-1:0]    miss_count;
	logic [STAT_W-1:0]    eviction_count;
	logic [ENT_OUT_W-1:0] entry_count;

	// shadow copy of the tag store used for prediction
	logic                 shadow_valid [ENTRY_N];
	logic [KEY_W-1:0]     shadow_key   [ENTRY_N];
	logic [STAMP_W-1:0]   shadow_stamp [ENTRY_N];
	logic [STAMP_W-1:0]   use_tick     = '0;
	logic [STAT_W-1:0]    hit_total    = '0;
	logic [STAT_W-1:0]    miss_total   = '0;
	logic [STAT_W-1:0]    evict_total  = '0;
	int unsigned          filled       = 0;

	// results predicted at each accepted transfer, oldest first
	cache_outcome_t       outcome_q [$];

	int unsigned          error_count  = 0;
	int unsigned          items_sent   = 0;
	int unsigned          results_seen = 0;
	int unsigned          cycle_count  = 0;
	int unsigned          idle_pct     = 0;
	int unsigned          phase_idx    = 0;
	int unsigned          phase_pct [4] = '{0, 68, 0, 38};

	lru_tag_cache u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.key            (key),
		.count_miss     (count_miss),
		.done           (done),
		.hit            (hit),
		.slot           (slot),
		.evicted        (evicted),
		.hit_count      (hit_count),
		.miss_count     (miss_count),
		.eviction_count (eviction_count),
		.entry_count    (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// clear the shadow store; stamps and keys are only read once valid
	initial begin
		for (int i = 0; i < ENTRY_N; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i]   = '0;
			shadow_stamp[i] = '0;
		end
	end

	// apply one request to the shadow store and return what the block must report
	function automatic cache_outcome_t lru_predict(logic act, logic [KEY_W-1:0] k, logic cm);
		cache_outcome_t     r;
		logic               found;
		int unsigned        target;
		logic [STAMP_W-1:0] oldest;
		r      = '0;
		found  = 1'b0;
		target = 0;
		if (act == ACT_LOOKUP) begin
			// first valid match in index order wins, so duplicates resolve to the lowest slot
			for (int i = 0; i < ENTRY_N; i++) begin
				if (!found && shadow_valid[i] && shadow_key[i] == k) begin
					found           = 1'b1;
					use_tick        = use_tick + 1;
					shadow_stamp[i] = use_tick;
					r.slot          = SLOT_W'(i);
				end
			end
			r.hit = found;
			if (found)
				hit_total = hit_total + 1;
			else if (cm)
				miss_total = miss_total + 1;
		end else begin
			// lowest free slot first
			for (int i = 0; i < ENTRY_N; i++) begin
				if (!found && !shadow_valid[i]) begin
					found  = 1'b1;
					target = i;
				end
			end
			if (!found) begin
				// store full: smallest stamp, lowest index on a tie
				target = 0;
				oldest = shadow_stamp[0];
				for (int i = 1; i < ENTRY_N; i++) begin
					if (shadow_stamp[i] < oldest) begin
						oldest = shadow_stamp[i];
						target = i;
					end
				end
				r.evicted   = 1'b1;
				evict_total = evict_total + 1;
			end else begin
				shadow_valid[target] = 1'b1;
				filled++;
			end
			// no duplicate check on insert
			shadow_key[target]   = k;
			use_tick             = use_tick + 1;
			shadow_stamp[target] = use_tick;
			r.slot               = SLOT_W'(target);
		end
		r.hit_count      = hit_total;
		r.miss_count     = miss_total;
		r.eviction_count = evict_total;
		r.entry_count    = ENT_OUT_W'(filled);
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	// a key already in the store, chosen at random among the filled slots
	function automatic logic [KEY_W-1:0] stored_key();
		return shadow_key[$urandom_range(filled - 1)];
	endfunction

	// compare one field and report a mismatch with time, expected and actual value
	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			if (error_count < MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, exp_v, got_v);
			error_count++;
		end
	endtask

	// result checker: every done strobe is one transfer that cannot be held off
	always @(posedge clk) begin
		cache_outcome_t exp_r;
		if (arst_n && done) begin
			results_seen++;
			if (outcome_q.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("%0t ns: result with nothing expected, slot 0x%0h",
						$time, slot);
				error_count++;
			end else begin
				exp_r = outcome_q.pop_front();
				check_field("hit",            exp_r.hit,            hit);
				check_field("slot",           exp_r.slot,           slot);
				check_field("evicted",        exp_r.evicted,        evicted);
				check_field("hit_count",      exp_r.hit_count,      hit_count);
				check_field("miss_count",     exp_r.miss_count,     miss_count);
				check_field("eviction_count", exp_r.eviction_count, eviction_count);
				check_field("entry_count",    exp_r.entry_count,    entry_count);
			end
		end
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: run exceeded %0d cycles, %0d results still expected",
				$time, CYCLE_LIMIT, outcome_q.size());
			$display("[lru_tag_cache] ERROR");
			$finish;
		end
	end

	// random sender idling: start low for a geometric number of cycles
	task automatic sender_gap();
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	// one request transfer; start stays high so back-to-back requests never toggle it
	task automatic send_request(logic act, logic [KEY_W-1:0] k, logic cm);
		sender_gap();
		start      <= 1'b1;
		action     <= act;
		key        <= k;
		count_miss <= cm;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// accepted at this edge: predict in acceptance order
		outcome_q.push_back(lru_predict(act, k, cm));
		items_sent++;
	endtask

	// hold off the sender until every expected result has come back
	task automatic drain_results();
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	// new idling phase; each change drains first so the sender pauses on an empty block
	task automatic next_phase();
		drain_results();
		phase_idx = (phase_idx + 1) % 4;
		idle_pct  = phase_pct[phase_idx];
	endtask

	// one random request; insert_pct sets the mix, the rest splits between hits and misses
	task automatic random_request(int unsigned insert_pct);
		int unsigned      pick;
		logic [KEY_W-1:0] k;
		pick = $urandom_range(99);
		if (items_sent % PHASE_LEN == 0)
			next_phase();
		if (pick < insert_pct) begin
			// mostly fresh keys, some duplicates of stored ones
			if (filled != 0 && $urandom_range(9) == 0)
				k = stored_key();
			else
				k = random_key();
			send_request(ACT_INSERT, k, 1'($urandom_range(1)));
		end else if (filled != 0 && pick < insert_pct + (100 - insert_pct) * 2 / 3) begin
			// hit on a stored key, refreshing its stamp
			send_request(ACT_LOOKUP, stored_key(), 1'($urandom_range(1)));
		end else begin
			// miss: random key or a stored key with one bit flipped, counted or probe only
			if (filled != 0 && $urandom_range(1))
				k = stored_key() ^ (64'd1 << $urandom_range(KEY_W - 1));
			else
				k = random_key();
			send_request(ACT_LOOKUP, k, 1'($urandom_range(1)));
		end
	endtask

	// lookups into an empty store: counted miss and probe only
	task automatic test_empty_lookup();
		send_request(ACT_LOOKUP, 64'h0, 1'b1);
		send_request(ACT_LOOKUP, '1, 1'b0);
		send_request(ACT_LOOKUP, random_key(), 1'b1);
	endtask

	// extreme and alternating key patterns, then hits and near misses on them
	task automatic test_key_extremes();
		send_request(ACT_INSERT, 64'h0, 1'b0);
		send_request(ACT_INSERT, '1, 1'b1);
		send_request(ACT_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_request(ACT_INSERT, 64'h5555_5555_5555_5555, 1'b1);
		send_request(ACT_LOOKUP, 64'h5555_5555_5555_5555, 1'b1);
		send_request(ACT_LOOKUP, '1, 1'b0);
		send_request(ACT_LOOKUP, 64'h0, 1'b1);
		send_request(ACT_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_request(ACT_LOOKUP, 64'h1, 1'b1);
		send_request(ACT_LOOKUP, 64'h8000_0000_0000_0000, 1'b0);
	endtask

	// duplicate insert stores a second copy; lookups still resolve to the lowest slot
	task automatic test_duplicate_insert();
		send_request(ACT_INSERT, '1, 1'b0);
		send_request(ACT_LOOKUP, '1, 1'b1);
		send_request(ACT_INSERT, 64'h0, 1'b1);
		send_request(ACT_LOOKUP, 64'h0, 1'b0);
	endtask

	// random traffic until every slot holds a key
	task automatic test_fill_to_capacity();
		while (filled < ENTRY_N)
			random_request(60);
	endtask

	// full store: inserts evict the least recent entry while hits keep reshuffling stamps
	task automatic test_lru_eviction();
		while (items_sent < ITEM_TARGET)
			random_request(35);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_lookup();
		test_key_extremes();
		test_duplicate_insert();
		test_fill_to_capacity();
		test_lru_eviction();
		// wait out the last result, then watch for stray strobes
		drain_results();
		repeat (ENTRY_N + 16) @(posedge clk);
		$display("covered %0d requests over %0d cycles: %0d hits, %0d counted misses,",
			items_sent, cycle_count, hit_total, miss_total);
		$display("%0d evictions on a store of %0d entries, %0d results checked",
			evict_total, filled, results_seen);
		if (error_count == 0)
			$display("[lru_tag_cache] OK");
		else
			$display("[lru_tag_cache] ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/ltc_pkg.sv
hdl/ltc_mem.sv
hdl/ltc_ctrl.sv
hdl/lru_tag_cache.sv
hdl/ltc_chk.sv
test/tb_lru_tag_cache.sv
